// File: rtl/poc_pkg.sv
// Shared types and constants of the pairwise overlap checker.
// Field widths, the reset value of the cut factor, the controller state enum and the
// command/status structs between controller and datapath. No dependencies.
package poc_pkg;

    localparam int POS_W     = 24;   // signed Q12.12 position
    localparam int DIA_W     = 23;   // unsigned Q11.12 diameter
    localparam int CUT_W     = 16;   // unsigned Q0.16 cut factor
    localparam int IDX_OUT_W = 5;    // index fields on the result ports
    localparam int DIST_W    = 51;   // squared distance on the result port
    localparam int DIFF_W    = 25;   // position difference
    localparam int SQ_W      = 48;   // one squared difference
    localparam int D2_W      = 49;   // dx^2 + dy^2
    localparam int SUM_W     = 24;   // sum of two diameters
    localparam int R_W       = 40;   // cut * (si + sj)
    localparam int HALF_W    = 20;   // half of R_W, for the split square
    localparam int R2_W      = 80;   // r^2
    localparam int SHIFT     = 34;   // scale between d2 and r^2
    localparam int CMP_W     = D2_W + SHIFT;

    localparam logic [CUT_W-1:0] CUT_RESET = 16'd62259;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT
    } t_ctl_state;

    // controller -> datapath
    typedef struct packed {
        logic store;    // write the incoming particle, latch it as the probe
        logic err;      // emit a capacity error result
        logic rd_en;    // read one stored particle into the compare pipeline
        logic rd_last;  // this read is the final one of the scan
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic done;     // scan fully drained, final result (if any) goes into the result register
    } t_dp_status;

endpackage

// File: rtl/poc_ctrl.sv
// Controller of the pairwise overlap checker: particle count, scan index, state machine.
// Uses poc_pkg (state enum, command and status structs).
module poc_ctrl #(
    parameter int MAX_PARTICLES = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_start_set,
    output logic                 o_busy,
    output poc_pkg::t_dp_cmd     o_cmd,
    output logic [$clog2(MAX_PARTICLES)-1:0] o_wr_addr,
    output logic [$clog2(MAX_PARTICLES)-1:0] o_rd_addr,
    input  poc_pkg::t_dp_status  i_stat
);
    import poc_pkg::*;

    localparam int IDX_W = $clog2(MAX_PARTICLES);
    localparam int CNT_W = $clog2(MAX_PARTICLES + 1);

    t_ctl_state       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_n, n_n;
    logic [IDX_W-1:0] r_scan, n_scan;
    logic [CNT_W-1:0] eff_count;
    logic             full;
    logic             scan_last;

    assign eff_count = i_start_set ? '0 : r_count;
    assign full      = (eff_count >= CNT_W'(MAX_PARTICLES));
    assign scan_last = ((CNT_W'(r_scan) + CNT_W'(1)) == r_n);
    assign o_busy    = (r_state != ST_IDLE);
    assign o_wr_addr = eff_count[IDX_W-1:0];
    assign o_rd_addr = r_scan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_n     <= '0;
            r_scan  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_n     <= n_n;
            r_scan  <= n_scan;
        end
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_n     = r_n;
        n_scan  = r_scan;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    if (full) begin
                        o_cmd.err = 1'b1;
                    end else begin
                        o_cmd.store = 1'b1;
                        n_count     = eff_count + CNT_W'(1);
                        if (eff_count != '0) begin
                            n_n     = eff_count;
                            n_scan  = '0;
                            n_state = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_last = scan_last;
                n_scan        = r_scan + IDX_W'(1);
                if (scan_last) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (i_stat.done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (CNT_W'(r_scan) < r_n))
        else $error("scan index reached the particle count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_PARTICLES))
        else $error("particle count above capacity");

    a_full_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_start && full) |=> (r_state == ST_IDLE))
        else $error("dropped particle started a scan");

endmodule

// File: rtl/poc_datapath.sv
// Datapath of the pairwise overlap checker: particle store, five-stage distance and
// threshold pipeline, pending-result register and result outputs. Uses poc_pkg.
module poc_datapath #(
    parameter int MAX_PARTICLES = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  poc_pkg::t_dp_cmd                    i_cmd,
    input  logic [$clog2(MAX_PARTICLES)-1:0]    i_wr_addr,
    input  logic [$clog2(MAX_PARTICLES)-1:0]    i_rd_addr,
    input  logic signed [poc_pkg::POS_W-1:0]    i_pos_x,
    input  logic signed [poc_pkg::POS_W-1:0]    i_pos_y,
    input  logic [poc_pkg::DIA_W-1:0]           i_diameter,
    input  logic                                i_cfg_we,
    input  logic [poc_pkg::CUT_W-1:0]           i_cfg_data,
    output poc_pkg::t_dp_status                 o_stat,
    output logic                                o_res_valid,
    output logic [poc_pkg::IDX_OUT_W-1:0]       o_new_index,
    output logic [poc_pkg::IDX_OUT_W-1:0]       o_other_index,
    output logic [poc_pkg::DIST_W-1:0]          o_dist_sq,
    output logic                                o_capacity_error,
    output logic                                o_last_of_run
);
    import poc_pkg::*;

    localparam int IDX_W = $clog2(MAX_PARTICLES);

    // particle store
    logic [POS_W-1:0] mem_x [MAX_PARTICLES];
    logic [POS_W-1:0] mem_y [MAX_PARTICLES];
    logic [DIA_W-1:0] mem_d [MAX_PARTICLES];

    logic [CUT_W-1:0] r_cut;

    // probe particle
    logic [POS_W-1:0] r_xi, r_yi;
    logic [DIA_W-1:0] r_si;
    logic [IDX_W-1:0] r_new_idx;

    // stage 1: memory read
    logic             r_s1_v, r_s1_last;
    logic [IDX_W-1:0] r_s1_j;
    logic [POS_W-1:0] r_s1_x, r_s1_y;
    logic [DIA_W-1:0] r_s1_d;
    // stage 2: differences and diameter sum
    logic                     r_s2_v, r_s2_last;
    logic [IDX_W-1:0]         r_s2_j;
    logic signed [DIFF_W-1:0] r_s2_dx, r_s2_dy;
    logic [SUM_W-1:0]         r_s2_sum;
    // stage 3: squares and scaled radius
    logic             r_s3_v, r_s3_last;
    logic [IDX_W-1:0] r_s3_j;
    logic [SQ_W-1:0]  r_s3_sqx, r_s3_sqy;
    logic [R_W-1:0]   r_s3_r;
    // stage 4: distance sum and partial products of r^2
    logic             r_s4_v, r_s4_last;
    logic [IDX_W-1:0] r_s4_j;
    logic [D2_W-1:0]  r_s4_d2;
    logic [R_W-1:0]   r_s4_hh, r_s4_hl, r_s4_ll;
    // stage 5: r^2 assembled
    logic             r_s5_v, r_s5_last;
    logic [IDX_W-1:0] r_s5_j;
    logic [D2_W-1:0]  r_s5_d2;
    logic [R2_W-1:0]  r_s5_r2;

    // pending overlap, held until the next one shows whether it is the last
    logic             r_pend_v;
    logic [IDX_W-1:0] r_pend_j;
    logic [D2_W-1:0]  r_pend_d2;
    logic             r_flush;

    // result register
    logic             r_out_v, r_out_err, r_out_last;
    logic [IDX_W-1:0] r_out_new, r_out_other;
    logic [D2_W-1:0]  r_out_d2;

    logic signed [2*DIFF_W-1:0] sq_x, sq_y;
    logic [R_W-1:0]             n_r, n_hh, n_hl, n_ll;
    logic [HALF_W-1:0]          r_hi, r_lo;
    logic [R2_W-1:0]            n_r2;
    logic                       hit;
    logic                       emit_pend, emit_final;
    logic [IDX_W+IDX_OUT_W-1:0] new_ext, other_ext;

    assign sq_x = r_s2_dx * r_s2_dx;
    assign sq_y = r_s2_dy * r_s2_dy;
    assign n_r  = R_W'(r_cut) * R_W'(r_s2_sum);
    assign r_hi = r_s3_r[R_W-1:HALF_W];
    assign r_lo = r_s3_r[HALF_W-1:0];
    assign n_hh = R_W'(r_hi) * R_W'(r_hi);
    assign n_hl = R_W'(r_hi) * R_W'(r_lo);
    assign n_ll = R_W'(r_lo) * R_W'(r_lo);
    assign n_r2 = (R2_W'(r_s4_hh) << (2 * HALF_W)) + (R2_W'(r_s4_hl) << (HALF_W + 1))
                + R2_W'(r_s4_ll);
    // d2 < ceil(r^2 / 2^34) is the same as d2 * 2^34 < r^2 for integer d2
    assign hit  = ({r_s5_d2, {SHIFT{1'b0}}} < CMP_W'(r_s5_r2));

    assign emit_pend  = r_s5_v && hit && r_pend_v;
    assign emit_final = r_flush && r_pend_v;

    assign o_stat.done = r_flush;

    // memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            mem_x[i_wr_addr] <= i_pos_x;
            mem_y[i_wr_addr] <= i_pos_y;
            mem_d[i_wr_addr] <= i_diameter;
        end
        r_s1_x <= mem_x[i_rd_addr];
        r_s1_y <= mem_y[i_rd_addr];
        r_s1_d <= mem_d[i_rd_addr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cut     <= CUT_RESET;
            r_s1_v    <= 1'b0;
            r_s2_v    <= 1'b0;
            r_s3_v    <= 1'b0;
            r_s4_v    <= 1'b0;
            r_s5_v    <= 1'b0;
            r_s1_last <= 1'b0;
            r_s2_last <= 1'b0;
            r_s3_last <= 1'b0;
            r_s4_last <= 1'b0;
            r_s5_last <= 1'b0;
            r_pend_v  <= 1'b0;
            r_flush   <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cut <= i_cfg_data;
            end
            r_s1_v    <= i_cmd.rd_en;
            r_s1_last <= i_cmd.rd_en && i_cmd.rd_last;
            r_s2_v    <= r_s1_v;
            r_s2_last <= r_s1_last;
            r_s3_v    <= r_s2_v;
            r_s3_last <= r_s2_last;
            r_s4_v    <= r_s3_v;
            r_s4_last <= r_s3_last;
            r_s5_v    <= r_s4_v;
            r_s5_last <= r_s4_last;
            r_flush   <= r_s5_v && r_s5_last;
            if (r_s5_v && hit) begin
                r_pend_v <= 1'b1;
            end else if (r_flush) begin
                r_pend_v <= 1'b0;
            end
            r_out_v <= i_cmd.err || emit_pend || emit_final;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_xi      <= i_pos_x;
            r_yi      <= i_pos_y;
            r_si      <= i_diameter;
            r_new_idx <= i_wr_addr;
        end
        r_s1_j   <= i_rd_addr;
        r_s2_j   <= r_s1_j;
        r_s2_dx  <= $signed({r_xi[POS_W-1], r_xi}) - $signed({r_s1_x[POS_W-1], r_s1_x});
        r_s2_dy  <= $signed({r_yi[POS_W-1], r_yi}) - $signed({r_s1_y[POS_W-1], r_s1_y});
        r_s2_sum <= SUM_W'(r_si) + SUM_W'(r_s1_d);
        r_s3_j   <= r_s2_j;
        r_s3_sqx <= sq_x[SQ_W-1:0];
        r_s3_sqy <= sq_y[SQ_W-1:0];
        r_s3_r   <= n_r;
        r_s4_j   <= r_s3_j;
        r_s4_d2  <= D2_W'(r_s3_sqx) + D2_W'(r_s3_sqy);
        r_s4_hh  <= n_hh;
        r_s4_hl  <= n_hl;
        r_s4_ll  <= n_ll;
        r_s5_j   <= r_s4_j;
        r_s5_d2  <= r_s4_d2;
        r_s5_r2  <= n_r2;
        if (r_s5_v && hit) begin
            r_pend_j  <= r_s5_j;
            r_pend_d2 <= r_s5_d2;
        end
        if (i_cmd.err) begin
            r_out_err   <= 1'b1;
            r_out_last  <= 1'b1;
            r_out_new   <= '0;
            r_out_other <= '0;
            r_out_d2    <= '0;
        end else begin
            r_out_err   <= 1'b0;
            r_out_last  <= emit_final;
            r_out_new   <= r_new_idx;
            r_out_other <= r_pend_j;
            r_out_d2    <= r_pend_d2;
        end
    end

    assign new_ext          = {{IDX_OUT_W{1'b0}}, r_out_new};
    assign other_ext        = {{IDX_OUT_W{1'b0}}, r_out_other};
    assign o_res_valid      = r_out_v;
    assign o_new_index      = new_ext[IDX_OUT_W-1:0];
    assign o_other_index    = other_ext[IDX_OUT_W-1:0];
    assign o_dist_sq        = DIST_W'(r_out_d2);
    assign o_capacity_error = r_out_err;
    assign o_last_of_run    = r_out_last;

    a_err_result_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out_err) |-> (r_out_last && r_out_d2 == '0 && r_out_other == '0))
        else $error("capacity error result carries data");

    a_flush_empties_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush |=> !r_pend_v)
        else $error("pending overlap survived the end of a scan");

    a_no_read_while_draining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush |-> !(r_s1_v || r_s2_v || r_s3_v || r_s4_v || r_s5_v))
        else $error("compare pipeline not empty at end of scan");

endmodule

// File: rtl/pairwise_overlap_checker.sv
// Top level of the pairwise overlap checker: joins the controller and the datapath.
// Depends on poc_pkg, poc_ctrl and poc_datapath.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+------------------------------------
//  particle | in        | start, busy                | i_start_set, i_pos_x, i_pos_y,
//           |           |                            | i_diameter
//  result   | out       | o_res_valid (strobe)       | o_new_index, o_other_index,
//           |           |                            | o_dist_sq, o_capacity_error,
//           |           |                            | o_last_of_run
//  config   | in        | i_cfg_valid, o_cfg_ready   | i_cfg_data (cut factor, Q0.16)
//
// A particle is taken when start is high and busy low. With particles already in the set,
// busy stays high while they are read, one stored particle per cycle, then while they pass
// five pipeline stages and a flush; the next particle can be taken once busy falls again.
// A particle into an empty set, or one dropped because the store is full, leaves busy low.
// Results are one-cycle strobes, the final one in the same cycle in which busy falls.
// Reset (synchronous, active low) empties the set and loads the cut factor with 0.95.
module pairwise_overlap_checker #(
    parameter int MAX_PARTICLES = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // particle transaction
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_start_set,
    input  logic signed [poc_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [poc_pkg::POS_W-1:0]   i_pos_y,
    input  logic [poc_pkg::DIA_W-1:0]          i_diameter,
    // result transaction
    output logic                               o_res_valid,
    output logic [poc_pkg::IDX_OUT_W-1:0]      o_new_index,
    output logic [poc_pkg::IDX_OUT_W-1:0]      o_other_index,
    output logic [poc_pkg::DIST_W-1:0]         o_dist_sq,
    output logic                               o_capacity_error,
    output logic                               o_last_of_run,
    // configuration transaction
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [poc_pkg::CUT_W-1:0]          i_cfg_data
);
    import poc_pkg::*;

    localparam int IDX_W = $clog2(MAX_PARTICLES);

    t_dp_cmd          cmd;
    t_dp_status       stat;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    logic             start_accept;

    // Take a register write in any cycle; writes must come only while idle, which the block does not enforce.
    assign o_cfg_ready  = 1'b1;
    // Only an accepted transaction may start the controller.
    assign start_accept = start && !busy;

    // Controller: holds the particle count, walks the stored particles, waits for drain.
    poc_ctrl #(
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start_accept),
        .i_start_set (i_start_set),
        .o_busy      (busy),
        .o_cmd       (cmd),
        .o_wr_addr   (wr_addr),
        .o_rd_addr   (rd_addr),
        .i_stat      (stat)
    );

    // Datapath: store, distance and threshold pipeline, result register.
    poc_datapath #(
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_wr_addr        (wr_addr),
        .i_rd_addr        (rd_addr),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_diameter       (i_diameter),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_stat           (stat),
        .o_res_valid      (o_res_valid),
        .o_new_index      (o_new_index),
        .o_other_index    (o_other_index),
        .o_dist_sq        (o_dist_sq),
        .o_capacity_error (o_capacity_error),
        .o_last_of_run    (o_last_of_run)
    );

    // A capacity error always stands alone as the last result of its transaction.
    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_capacity_error) |-> o_last_of_run)
        else $error("capacity error result not marked last");

    // No result appears while idle unless it is marked last: the final one of a scan or that of a dropped particle.
    a_last_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_last_of_run) |-> busy)
        else $error("non-final result outside a scan");

    // A drained scan returns to idle.
    a_done_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.done |=> !busy)
        else $error("controller stayed busy after drain");

endmodule

// File: test/pairwise_overlap_checker_tb.sv
// Self-checking testbench for pairwise_overlap_checker: directed table, then random particle sets.
// Results are checked field by field against the table or a local predictor of the all-pairs scan.
// Depends on poc_pkg and pairwise_overlap_checker.
`timescale 1ns / 1ps

module pairwise_overlap_checker_tb;
    import poc_pkg::*;

    localparam int MAX_P         = 32;
    localparam int SETTLE_CYCLES = MAX_P + 16;   // longest scan plus pipeline drain
    localparam int CYCLE_LIMIT   = 200_000;
    localparam int WIDE_W        = 96;           // holds d2 << SHIFT and r^2 exactly
    localparam int PHASE_ITEMS   = 21;

    localparam logic signed [POS_W-1:0] POS_MAX  = 24'sh7F_FFFF;
    localparam logic signed [POS_W-1:0] POS_MIN  = 24'sh80_0000;
    localparam logic signed [POS_W-1:0] POS_ZERO = 24'sh00_0000;
    localparam logic [DIA_W-1:0]        DIA_MAX  = 23'h7F_FFFF;
    localparam logic [DIA_W-1:0]        DIA_ONE  = 23'h00_1000;   // 1.0 in Q11.12
    localparam logic [CUT_W-1:0]        CUT_MAX  = 16'hFFFF;
    localparam logic [CUT_W-1:0]        CUT_ZERO = 16'h0000;

    // One overlap report as it appears on the result ports.
    typedef struct packed {
        logic [IDX_OUT_W-1:0] new_idx;
        logic [IDX_OUT_W-1:0] other_idx;
        logic [DIST_W-1:0]    dsq;
        logic                 cap_err;
        logic                 last;
    } t_overlap;

    typedef enum logic {
        ROW_SEND,
        ROW_CUT
    } t_row_kind;

    // Directed row: either a particle sent reps times, or a cut factor write.
    // Where typed is set, the expectation is the row's own (none, or the one in res).
    typedef struct packed {
        t_row_kind            kind;
        logic [5:0]           reps;
        logic [CUT_W-1:0]     cut;
        logic                 ss;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [DIA_W-1:0]     dia;
        logic                 typed;
        logic                 typed_hit;
        t_overlap             res;
    } t_dir_row;

    localparam int NUM_ROWS = 20;

    t_dir_row dir_table [NUM_ROWS] = '{
        // first particle of a set: index 0, nothing to compare against
        '{ROW_SEND, 6'd1, CUT_ZERO, 1'b1, POS_ZERO, POS_ZERO, DIA_ONE, 1'b1, 1'b0, '0},
        // same spot: one overlap at distance zero
        '{ROW_SEND, 6'd1, CUT_ZERO, 1'b0, POS_ZERO, POS_ZERO, DIA_ONE, 1'b1, 1'b1,
          '{5'd1, 5'd0, 51'd0, 1'b0, 1'b1}},
        '{ROW_SEND, 6'd1, CUT_ZERO, 1'b0, POS_MAX, POS_MAX, 23'd0, 1'b0, 1'b0, '0},
        '{ROW_SEND, 6'd1, CUT_ZERO, 1'b0, POS_MIN, POS_MIN, DIA_MAX, 1'b0, 1'b0, '0},
        '{ROW_SEND, 6'd1, CUT_ZERO, 1'b0, POS_ZERO, POS_ZERO, DIA_MAX, 1'b0, 1'b0, '0},
        '{ROW_SEND, 6'd1, CUT_ZERO, 1'b0, POS_MIN, POS_MAX, DIA_MAX, 1'b0, 1'b0, '0},
        '{ROW_SEND, 6'd1, CUT_ZERO, 1'b0, POS_MAX, POS_MIN, DIA_MAX, 1'b0, 1'b0, '0},
        '{ROW_SEND, 6'd1, CUT_ZERO, 1'b0, 24'sh00_1000, 24'shFF_F000, 23'h2000,
          1'b0, 1'b0, '0},
        '{ROW_CUT,  6'd1, CUT_MAX,  1'b0, POS_ZERO, POS_ZERO, 23'd0, 1'b0, 1'b0, '0},
        '{ROW_SEND, 6'd1, CUT_ZERO, 1'b1, POS_ZERO, POS_ZERO, DIA_MAX, 1'b1, 1'b0, '0},
        '{ROW_SEND, 6'd1, CUT_ZERO, 1'b0, 24'sh12_3456, 24'shDA_BCDF, DIA_MAX,
          1'b0, 1'b0, '0},
        '{ROW_SEND, 6'd1, CUT_ZERO, 1'b0, 24'shC0_0001, 24'sh3F_FFFF, DIA_MAX,
          1'b0, 1'b0, '0},
        // zero cut factor: the threshold vanishes, nothing overlaps
        '{ROW_CUT,  6'd1, CUT_ZERO, 1'b0, POS_ZERO, POS_ZERO, 23'd0, 1'b0, 1'b0, '0},
        '{ROW_SEND, 6'd1, CUT_ZERO, 1'b0, POS_ZERO, POS_ZERO, DIA_MAX, 1'b1, 1'b0, '0},
        '{ROW_CUT,  6'd1, CUT_RESET, 1'b0, POS_ZERO, POS_ZERO, 23'd0, 1'b0, 1'b0, '0},
        // fill the store with zero-diameter particles: no overlaps at all
        '{ROW_SEND, 6'd1, CUT_ZERO, 1'b1, POS_ZERO, POS_ZERO, 23'd0, 1'b1, 1'b0, '0},
        '{ROW_SEND, 6'd31, CUT_ZERO, 1'b0, POS_ZERO, POS_ZERO, 23'd0, 1'b1, 1'b0, '0},
        // store full: dropped and flagged
        '{ROW_SEND, 6'd1, CUT_ZERO, 1'b0, 24'sh00_1000, 24'sh00_1000, DIA_ONE, 1'b1, 1'b1,
          '{5'd0, 5'd0, 51'd0, 1'b1, 1'b1}},
        // start flag on a full set: accepted as index 0
        '{ROW_SEND, 6'd1, CUT_ZERO, 1'b1, POS_ZERO, POS_ZERO, DIA_ONE, 1'b1, 1'b0, '0},
        '{ROW_SEND, 6'd1, CUT_ZERO, 1'b0, POS_ZERO, 24'sh00_0800, DIA_ONE, 1'b0, 1'b0, '0}
    };

    // DUT ports, all inputs known from time zero
    logic                     i_clk            = 1'b0;
    logic                     i_rst_n          = 1'b0;
    logic                     start            = 1'b0;
    logic                     busy;
    logic                     i_start_set      = 1'b0;
    logic signed [POS_W-1:0]  i_pos_x          = '0;
    logic signed [POS_W-1:0]  i_pos_y          = '0;
    logic [DIA_W-1:0]         i_diameter       = '0;
    logic                     o_res_valid;
    logic [IDX_OUT_W-1:0]     o_new_index;
    logic [IDX_OUT_W-1:0]     o_other_index;
    logic [DIST_W-1:0]        o_dist_sq;
    logic                     o_capacity_error;
    logic                     o_last_of_run;
    logic                     i_cfg_valid      = 1'b0;
    logic                     o_cfg_ready;
    logic [CUT_W-1:0]         i_cfg_data       = '0;

    // Predictor state: a mirror of the particle store and the cut factor.
    logic signed [POS_W-1:0]  mirror_x   [MAX_P];
    logic signed [POS_W-1:0]  mirror_y   [MAX_P];
    logic [DIA_W-1:0]         mirror_dia [MAX_P];
    int unsigned              set_size   = 0;
    logic [CUT_W-1:0]         cut_model  = CUT_RESET;

    t_overlap                 step_hits[$];         // overlaps of the latest particle
    t_overlap                 pending_overlaps[$];  // expected, not yet seen on the ports
    int unsigned              send_idle_pct = 0;
    int unsigned              fail_count    = 0;
    int unsigned              cycle_count   = 0;

    pairwise_overlap_checker #(.MAX_PARTICLES(MAX_P)) uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Compute the overlaps one particle causes and advance the mirrored store if it is not full.
    // The threshold test d2 < ceil(r^2 / 2^SHIFT) is done exactly as
    // d2 * 2^SHIFT < r^2 on wide vectors.
    function automatic void predict_overlaps(input logic ss,
                                             input logic signed [POS_W-1:0] px,
                                             input logic signed [POS_W-1:0] py,
                                             input logic [DIA_W-1:0] dia);
        longint          dx, dy;
        bit [63:0]       d2;
        bit [R_W-1:0]    reach;
        bit [WIDE_W-1:0] scaled_d2, reach_sq;
        t_overlap        hit;
        step_hits.delete();
        if (ss)
            set_size = 0;
        if (set_size >= MAX_P) begin
            // drop the particle, report the full store
            hit         = '0;
            hit.cap_err = 1'b1;
            hit.last    = 1'b1;
            step_hits.insert(step_hits.size(), hit);
            return;
        end
        for (int j = 0; j < set_size; j++) begin
            dx        = longint'(px) - longint'(mirror_x[j]);
            dy        = longint'(py) - longint'(mirror_y[j]);
            d2        = dx * dx + dy * dy;
            reach     = R_W'(cut_model) * (R_W'(dia) + R_W'(mirror_dia[j]));
            scaled_d2 = WIDE_W'(d2) << SHIFT;
            reach_sq  = WIDE_W'(reach) * WIDE_W'(reach);
            if (scaled_d2 < reach_sq) begin
                hit           = '0;
                hit.new_idx   = IDX_OUT_W'(set_size);
                hit.other_idx = IDX_OUT_W'(j);
                hit.dsq       = d2[DIST_W-1:0];
                step_hits.insert(step_hits.size(), hit);
            end
        end
        if (step_hits.size() > 0)
            step_hits[step_hits.size() - 1].last = 1'b1;
        mirror_x[set_size]   = px;
        mirror_y[set_size]   = py;
        mirror_dia[set_size] = dia;
        set_size++;
    endfunction

    // Offer one particle; hold it until the block takes it, then queue what it causes.
    // An idle gap of random length lets the next start land anywhere in the scan.
    task automatic send_particle(input logic ss,
                                 input logic signed [POS_W-1:0] px,
                                 input logic signed [POS_W-1:0] py,
                                 input logic [DIA_W-1:0] dia,
                                 input logic typed,
                                 input logic typed_hit,
                                 input t_overlap typed_res);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 48)) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_start_set <= ss;
        i_pos_x     <= px;
        i_pos_y     <= py;
        i_diameter  <= dia;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        predict_overlaps(ss, px, py, dia);
        if (typed) begin
            if (typed_hit)
                pending_overlaps.insert(pending_overlaps.size(), typed_res);
        end else begin
            foreach (step_hits[h])
                pending_overlaps.insert(pending_overlaps.size(), step_hits[h]);
        end
    endtask

    // Drop start, wait for every expected overlap, then let a silent scan finish.
    task automatic wait_quiet();
        start <= 1'b0;
        while (pending_overlaps.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the cut factor while the block is idle.
    task automatic write_cut(input logic [CUT_W-1:0] value);
        wait_quiet();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do
            @(posedge i_clk);
        while (o_cfg_ready !== 1'b1);
        cut_model   = value;
        i_cfg_valid <= 1'b0;
    endtask

    // Random sets: mostly clustered particles that overlap often, with a share of
    // fully random noise particles; the last set is cut off at the end of the phase.
    task automatic run_random_phase(input int unsigned idle_pct);
        int unsigned             sent, set_len;
        int                      off_x, off_y;
        logic                    ss;
        logic signed [POS_W-1:0] cx, cy, px, py;
        logic [DIA_W-1:0]        dia;
        write_cut(CUT_W'($urandom_range(24576, 65535)));
        send_idle_pct = idle_pct;
        sent = 0;
        while (sent < PHASE_ITEMS) begin
            set_len = $urandom_range(2, 12);
            cx = POS_W'($urandom);
            cy = POS_W'($urandom);
            for (int k = 0; k < set_len && sent < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    ss  = 1'($urandom_range(0, 1));
                    px  = POS_W'($urandom);
                    py  = POS_W'($urandom);
                    dia = DIA_W'($urandom);
                end else begin
                    off_x = int'($urandom_range(0, 32767)) - 16384;
                    off_y = int'($urandom_range(0, 32767)) - 16384;
                    ss    = (k == 0);
                    px    = cx + POS_W'(off_x);
                    py    = cy + POS_W'(off_y);
                    dia   = DIA_W'($urandom_range(1024, 36864));
                end
                send_particle(ss, px, py, dia, 1'b0, 1'b0, '0);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        send_idle_pct = 18;
        foreach (dir_table[r]) begin
            if (dir_table[r].kind == ROW_CUT) begin
                write_cut(dir_table[r].cut);
            end else begin
                repeat (dir_table[r].reps)
                    send_particle(dir_table[r].ss, dir_table[r].x, dir_table[r].y,
                                  dir_table[r].dia, dir_table[r].typed,
                                  dir_table[r].typed_hit, dir_table[r].res);
            end
        end

        // random phases: light sender gaps, heavy gaps, then back to back
        run_random_phase(18);
        run_random_phase(49);
        run_random_phase(0);

        wait_quiet();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Check each result strobe against the oldest pending overlap.
    always @(posedge i_clk) begin
        t_overlap want;
        if (i_rst_n && o_res_valid === 1'b1) begin
            if (pending_overlaps.size() == 0) begin
                $error("unexpected result: new_index %0d other_index %0d dist_sq %0d",
                       o_new_index, o_other_index, o_dist_sq);
                fail_count++;
            end else begin
                want = pending_overlaps.pop_front();
                if (o_new_index !== want.new_idx) begin
                    $error("new_index: expected %0d, actual %0d", want.new_idx, o_new_index);
                    fail_count++;
                end
                if (o_other_index !== want.other_idx) begin
                    $error("other_index: expected %0d, actual %0d",
                           want.other_idx, o_other_index);
                    fail_count++;
                end
                if (o_dist_sq !== want.dsq) begin
                    $error("dist_sq: expected %0d, actual %0d", want.dsq, o_dist_sq);
                    fail_count++;
                end
                if (o_capacity_error !== want.cap_err) begin
                    $error("capacity_error: expected %0d, actual %0d",
                           want.cap_err, o_capacity_error);
                    fail_count++;
                end
                if (o_last_of_run !== want.last) begin
                    $error("last_of_run: expected %0d, actual %0d",
                           want.last, o_last_of_run);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule
